>>> sv/haar_modwt_decompose_defines.svh
// haar_modwt_decompose_defines.svh
// Assertion macros for the Haar MODWT block; they expect clk and rst in scope.
// No other dependencies.
`ifndef HAAR_MODWT_DECOMPOSE_DEFINES_SVH
`define HAAR_MODWT_DECOMPOSE_DEFINES_SVH
`ifndef ASSERT_OFF
`define HMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HMD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HMD_ASSERT(lbl, prop, msg)
`define HMD_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> sv/hmd_pkg.sv
// hmd_pkg.sv
// Shared constants, codes and types of the Haar MODWT block.
// No dependencies.
`timescale 1ns / 1ps

package hmd_pkg;

  localparam int MAX_LEN_DEF     = 1024;
  localparam int MAX_LEVELS_DEF  = 10;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;
  localparam int LEVELS_W = 4;
  localparam int ROW_W    = 4;
  localparam int POS_W    = 10;

  // register select is paddr[2]
  localparam logic REG_LEVELS = 1'b0;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_LEVELS = 2'd1,
    STAT_RANGE  = 2'd2,
    STAT_DROP   = 2'd3
  } status_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDWAIT,
    ST_START,
    ST_LVL_A,
    ST_LVL_B,
    ST_LVL_DIFF,
    ST_LVL_SUM,
    ST_CP_RD,
    ST_CP_WR
  } state_t;

  typedef struct packed {
    status_t               status;
    logic [LEVELS_W-1:0]   levels_used;
  } res_t;

endpackage

>>> sv/haar_modwt_decompose.sv
// Haar MODWT decomposition: loads a sample block, transforms it and serves
// coefficient reads. Sequencer, buffers, store and shared halving adder.
// Depends on hmd_pkg, hmd_ram, hmd_halfsum, hmd_skid and the defines header.
//
// Input channel (in_valid/in_stall): load items append a sample; the load with
// last_sample set closes the block of N samples. Read items fetch row/position
// from the stored matrix. Every item gives exactly one result transfer on the
// output channel (out_valid/out_stall). levels is set through the APB port.
// Loads: the result goes straight to the output register; one load per cycle
// while in_stall is low. Reads: the coefficient RAM's registered read in
// ST_RDWAIT, then the output register; in_stall is high in ST_RDWAIT, so the
// next item waits for the read. Closing load: the shared adder handles one
// level over N positions in four steps per position (two buffer reads, W
// write, V write), then the scaling row is copied in two steps per position.
// in_stall stays high until the result of the closing load is formed.
// A stalled receiver holds the result in the output register; one further
// item is still taken into the skid entry, then in_stall rises.
// Reset (synchronous) clears sample count, levels and the matrix valid flag;
// the RAMs are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`include "haar_modwt_decompose_defines.svh"

module haar_modwt_decompose
  import hmd_pkg::*;
#(
  parameter int MAX_LEN     = MAX_LEN_DEF,
  parameter int MAX_LEVELS  = MAX_LEVELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          operation,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          last_sample,
  input  logic [ROW_W-1:0]              row,
  input  logic [POS_W-1:0]              position,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] value,
  output logic [1:0]                    status,
  output logic [LEVELS_W-1:0]           levels_used
);

  localparam int SB     = SAMPLE_BITS;
  localparam int AW     = $clog2(MAX_LEN);
  localparam int CNT_W  = $clog2(MAX_LEN + 1);
  localparam int LG_W   = $clog2(CNT_W + 1);
  localparam int RW     = $clog2(MAX_LEVELS + 1);
  localparam int SDEPTH = (MAX_LEVELS + 1) << AW;

  state_t state, state_next;

  logic [LEVELS_W-1:0] levels;
  logic [CNT_W-1:0]    count;
  logic [LG_W-1:0]     lg;
  logic                dropped;
  logic [RW-1:0]       jtot;
  logic [RW-1:0]       lvl;
  logic [AW-1:0]       t;
  logic [SB-1:0]       a_reg;
  logic [SB-1:0]       b_reg;
  logic [CNT_W-1:0]    blen;
  logic [RW-1:0]       eff;
  logic                mat_valid;
  logic                rd_ok;

  logic             cfg_wr;
  logic             in_take;
  logic             is_load;
  logic             cnt_room;
  logic [RW-1:0]    top;
  logic             lev_bad;
  logic [RW-1:0]    j_sel;
  logic             t_last;
  logic             lvl_last;
  logic [CNT_W-1:0] shift_w;
  logic [CNT_W-1:0] tb_w;
  logic             rd_ok_now;
  logic             skid_full;

  logic             a_we, w_we, s_we;
  logic [AW-1:0]    a_waddr, buf_waddr, buf_raddr;
  logic [SB-1:0]    a_wdata, buf_wdata;
  logic [SB-1:0]    a_rdata, w_rdata, s_rdata, src_rdata;
  logic [RW+AW-1:0] s_waddr, s_raddr;
  logic [SB-1:0]    s_wdata;

  logic          alu_sub;
  logic [SB-1:0] alu_b, alu_y;

  logic          res_fire;
  logic [SB-1:0] res_value;
  res_t          res;
  res_t          out_res;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_LEVELS);
  assign prdata = (paddr[2] == REG_LEVELS) ? {(DATA_W - LEVELS_W)'(0), levels} : '0;

  assign in_stall = (state != ST_IDLE) || skid_full;
  assign in_take  = in_valid && !in_stall;
  assign is_load  = (operation == OP_LOAD);
  assign cnt_room = 32'(count) < MAX_LEN;

  assign top      = (32'(lg) > MAX_LEVELS) ? RW'(MAX_LEVELS) : RW'(lg);
  assign lev_bad  = 32'(levels) > 32'(top);
  assign j_sel    = (levels == '0) ? top : RW'(levels);
  assign t_last   = 32'(t) == 32'(count) - 1;
  assign lvl_last = (lvl + RW'(1)) == jtot;
  assign shift_w  = CNT_W'(1) << lvl;
  assign tb_w     = (CNT_W'(t) >= shift_w) ? CNT_W'(t) - shift_w
                                           : CNT_W'(t) + count - shift_w;

  assign rd_ok_now = mat_valid && (32'(row) <= 32'(eff)) && (32'(position) < 32'(blen));
  assign src_rdata = lvl[0] ? w_rdata : a_rdata;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          if (!is_load) begin
            state_next = ST_RDWAIT;
          end else if (last_sample) begin
            state_next = ST_START;
          end
        end
      end
      ST_RDWAIT: state_next = ST_IDLE;
      ST_START: begin
        if (lev_bad) begin
          state_next = ST_IDLE;
        end else if (j_sel == '0) begin
          state_next = ST_CP_RD;
        end else begin
          state_next = ST_LVL_A;
        end
      end
      ST_LVL_A:    state_next = ST_LVL_B;
      ST_LVL_B:    state_next = ST_LVL_DIFF;
      ST_LVL_DIFF: state_next = ST_LVL_SUM;
      ST_LVL_SUM:  state_next = (t_last && lvl_last) ? ST_CP_RD : ST_LVL_A;
      ST_CP_RD:    state_next = ST_CP_WR;
      ST_CP_WR:    state_next = t_last ? ST_IDLE : ST_CP_RD;
      default:     state_next = ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    a_we            = 1'b0;
    w_we            = 1'b0;
    s_we            = 1'b0;
    a_waddr         = t;
    a_wdata         = alu_y;
    buf_waddr       = t;
    buf_wdata       = alu_y;
    buf_raddr       = t;
    s_waddr         = {lvl, t};
    s_wdata         = alu_y;
    s_raddr         = {RW'(row), AW'(position)};
    alu_sub         = 1'b0;
    alu_b           = b_reg;
    res_fire        = 1'b0;
    res_value       = '0;
    res.status      = STAT_OK;
    res.levels_used = LEVELS_W'(eff);
    case (state)
      ST_IDLE: begin
        if (in_take && is_load) begin
          a_we     = cnt_room;
          a_waddr  = AW'(count);
          a_wdata  = sample;
          res_fire = !last_sample;
          res.status = cnt_room ? STAT_OK : STAT_DROP;
        end
      end
      ST_RDWAIT: begin
        res_fire   = 1'b1;
        res_value  = rd_ok ? s_rdata : '0;
        res.status = rd_ok ? STAT_OK : STAT_RANGE;
      end
      ST_START: begin
        res_fire        = lev_bad;
        res.status      = STAT_LEVELS;
        res.levels_used = '0;
      end
      ST_LVL_B: buf_raddr = AW'(tb_w);
      ST_LVL_DIFF: begin
        alu_sub = 1'b1;
        alu_b   = src_rdata;
        s_we    = 1'b1;
      end
      ST_LVL_SUM: begin
        a_we = lvl[0];
        w_we = !lvl[0];
      end
      ST_CP_WR: begin
        s_we            = 1'b1;
        s_waddr         = {jtot, t};
        s_wdata         = src_rdata;
        res_fire        = t_last;
        res.status      = dropped ? STAT_DROP : STAT_OK;
        res.levels_used = LEVELS_W'(jtot);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      levels    <= '0;
      count     <= '0;
      lg        <= '0;
      eff       <= '0;
      mat_valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        levels <= pwdata[LEVELS_W-1:0];
      end
      case (state)
        ST_IDLE: begin
          if (in_take && is_load && cnt_room) begin
            count <= count + CNT_W'(1);
            if (count == '0) begin
              lg <= '0;
            end else if (((count + CNT_W'(1)) & count) == '0) begin
              lg <= lg + LG_W'(1);
            end
          end
        end
        ST_START: begin
          mat_valid <= 1'b0;
          if (lev_bad) begin
            eff   <= '0;
            count <= '0;
            lg    <= '0;
          end
        end
        ST_CP_WR: begin
          if (t_last) begin
            eff       <= jtot;
            mat_valid <= 1'b1;
            count     <= '0;
            lg        <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          dropped <= !cnt_room;
          rd_ok   <= rd_ok_now;
        end
      end
      ST_START: begin
        jtot <= j_sel;
        lvl  <= '0;
        t    <= '0;
      end
      ST_LVL_B:    a_reg <= src_rdata;
      ST_LVL_DIFF: b_reg <= src_rdata;
      ST_LVL_SUM: begin
        if (t_last) begin
          t   <= '0;
          lvl <= lvl + RW'(1);
        end else begin
          t <= t + AW'(1);
        end
      end
      ST_CP_WR: begin
        if (t_last) begin
          blen <= count;
          t    <= '0;
        end else begin
          t <= t + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  hmd_ram #(.W(SB), .DEPTH(MAX_LEN)) u_abuf (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (buf_raddr),
    .rdata (a_rdata)
  );

  hmd_ram #(.W(SB), .DEPTH(MAX_LEN)) u_wbuf (
    .clk   (clk),
    .we    (w_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .raddr (buf_raddr),
    .rdata (w_rdata)
  );

  hmd_ram #(.W(SB), .DEPTH(SDEPTH)) u_store (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  hmd_halfsum #(.SB(SB)) u_alu (
    .a   (a_reg),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y)
  );

  hmd_skid #(.SB(SB)) u_skid (
    .clk       (clk),
    .rst       (rst),
    .res_fire  (res_fire),
    .res_value (res_value),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_value (value),
    .out_res   (out_res),
    .full      (skid_full)
  );

  assign status      = out_res.status;
  assign levels_used = out_res.levels_used;

  `HMD_ASSERT(a_busy_stall, (state != ST_IDLE) |-> in_stall, "item taken while busy")
  `HMD_ASSERT(a_skid_safe, (skid_full && out_valid && out_stall) |-> !res_fire, "result lost")
  `HMD_ASSERT(a_start_len, (state == ST_START) |-> (count != '0), "empty block computed")
  `HMD_ASSERT_RST(a_rst_clear, rst |=> (!mat_valid && count == '0), "reset not applied")

endmodule

>>> sv/hmd_ram.sv
// hmd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hmd_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/hmd_halfsum.sv
// hmd_halfsum.sv
// Shared add/subtract unit followed by an arithmetic halving (floor of half).
// No dependencies.
`timescale 1ns / 1ps

module hmd_halfsum #(
  parameter int SB = 16
) (
  input  logic [SB-1:0] a,
  input  logic [SB-1:0] b,
  input  logic          sub,
  output logic [SB-1:0] y
);

  logic [SB:0] sum;

  assign sum = sub ? ({a[SB-1], a} - {b[SB-1], b}) : ({a[SB-1], a} + {b[SB-1], b});
  assign y   = sum[SB:1];

endmodule

>>> sv/hmd_skid.sv
// hmd_skid.sv
// Output register plus one skid entry for result transfers.
// Depends on hmd_pkg.
`timescale 1ns / 1ps

module hmd_skid
  import hmd_pkg::*;
#(
  parameter int SB = SAMPLE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          res_fire,
  input  logic [SB-1:0] res_value,
  input  res_t          res,
  input  logic          out_stall,
  output logic          out_valid,
  output logic [SB-1:0] out_value,
  output res_t          out_res,
  output logic          full
);

  logic          skid_valid;
  logic [SB-1:0] skid_value;
  res_t          skid_res;
  logic          out_free;

  assign out_free = !out_valid || !out_stall;
  assign full     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || res_fire;
      skid_valid <= skid_valid && res_fire;
    end else if (res_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_value  <= skid_value;
        out_res    <= skid_res;
        skid_value <= res_value;
        skid_res   <= res;
      end else if (res_fire) begin
        out_value <= res_value;
        out_res   <= res;
      end
    end else if (res_fire) begin
      skid_value <= res_value;
      skid_res   <= res;
    end
  end

endmodule

>>> bench/haar_modwt_decompose_tb.sv
// haar_modwt_decompose_tb.sv
// Self-checking bench for haar_modwt_decompose: directed table, capacity blocks and random load/read
// traffic, checked against a behavioral MODWT predictor (typed table rows: their listed results). Needs hmd_pkg.
`timescale 1ns / 1ps

module haar_modwt_decompose_tb;
  import hmd_pkg::*;

  localparam int SW = SAMPLE_BITS_DEF;
  localparam int STALL_LIMIT = 200000;
  localparam logic [ADDR_W-1:0] LEVELS_ADDR = {REG_LEVELS, 2'b00};

  typedef struct packed {
    op_t                  op;
    logic signed [SW-1:0] smp;
    logic                 last;
    logic [ROW_W-1:0]     rw;
    logic [POS_W-1:0]     pos;
  } item_t;

  typedef struct packed {
    logic signed [SW-1:0] val;
    status_t              st;
    logic [LEVELS_W-1:0]  lv;
  } coef_res_t;

  typedef struct {
    int        cfg;
    item_t     it;
    bit        typed;
    coef_res_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic in_valid, in_stall, out_valid, out_stall;
  logic operation, last_sample;
  logic signed [SW-1:0] sample, value;
  logic [ROW_W-1:0] row;
  logic [POS_W-1:0] position;
  logic [1:0] status;
  logic [LEVELS_W-1:0] levels_used;

  haar_modwt_decompose dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .sample(sample), .last_sample(last_sample),
    .row(row), .position(position),
    .out_valid(out_valid), .out_stall(out_stall),
    .value(value), .status(status), .levels_used(levels_used)
  );

  always #5 clk = ~clk;

  // predictor state
  logic signed [SW-1:0] pv_coef [0:MAX_LEVELS_DEF][0:MAX_LEN_DEF-1];
  logic signed [SW-1:0] pv_buf [0:MAX_LEN_DEF-1];
  logic signed [SW-1:0] pv_work [0:MAX_LEN_DEF-1];
  int pv_count = 0;
  int pv_len = 0;
  logic [LEVELS_W-1:0] pv_eff = '0;
  logic [LEVELS_W-1:0] pv_levels = '0;
  bit pv_ok = 1'b0;

  coef_res_t exp_q [$];
  int errs = 0;
  int n_sent = 0;
  int burst_left = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  dir_row_t dir_tab [25] = '{
    '{-1, '{OP_READ, 16'sd0, 1'b0, 4'd0, 10'd0}, 1'b1, '{16'sd0, STAT_RANGE, 4'd0}},
    '{-1, '{OP_LOAD, 16'sh7fff, 1'b0, 4'd0, 10'd0}, 1'b1, '{16'sd0, STAT_OK, 4'd0}},
    '{-1, '{OP_LOAD, 16'sh8000, 1'b0, 4'd0, 10'd0}, 1'b1, '{16'sd0, STAT_OK, 4'd0}},
    '{-1, '{OP_LOAD, 16'sd1, 1'b1, 4'd0, 10'd0}, 1'b1, '{16'sd0, STAT_OK, 4'd1}},
    '{-1, '{OP_READ, 16'sd0, 1'b0, 4'd0, 10'd0}, 1'b0, '{16'sd0, STAT_OK, 4'd0}},
    '{-1, '{OP_READ, 16'sd0, 1'b0, 4'd0, 10'd2}, 1'b0, '{16'sd0, STAT_OK, 4'd0}},
    '{-1, '{OP_READ, 16'sd0, 1'b0, 4'd1, 10'd1}, 1'b0, '{16'sd0, STAT_OK, 4'd0}},
    '{-1, '{OP_READ, 16'sd0, 1'b0, 4'd2, 10'd0}, 1'b1, '{16'sd0, STAT_RANGE, 4'd1}},
    '{-1, '{OP_READ, 16'sd0, 1'b0, 4'd1, 10'd3}, 1'b1, '{16'sd0, STAT_RANGE, 4'd1}},
    '{-1, '{OP_READ, 16'sd0, 1'b0, 4'd15, 10'd1023}, 1'b1, '{16'sd0, STAT_RANGE, 4'd1}},
    '{-1, '{OP_LOAD, -16'sd5, 1'b1, 4'd0, 10'd0}, 1'b1, '{16'sd0, STAT_OK, 4'd0}},
    '{-1, '{OP_READ, 16'sd0, 1'b0, 4'd0, 10'd0}, 1'b1, '{-16'sd5, STAT_OK, 4'd0}},
    '{-1, '{OP_READ, 16'sd0, 1'b0, 4'd1, 10'd0}, 1'b1, '{16'sd0, STAT_RANGE, 4'd0}},
    '{3, '{OP_LOAD, 16'sd100, 1'b0, 4'd0, 10'd0}, 1'b1, '{16'sd0, STAT_OK, 4'd0}},
    '{-1, '{OP_READ, 16'sd0, 1'b0, 4'd0, 10'd0}, 1'b1, '{-16'sd5, STAT_OK, 4'd0}},
    '{-1, '{OP_LOAD, 16'sd7, 1'b0, 4'd0, 10'd0}, 1'b1, '{16'sd0, STAT_OK, 4'd0}},
    '{-1, '{OP_LOAD, -16'sd7, 1'b1, 4'd0, 10'd0}, 1'b1, '{16'sd0, STAT_LEVELS, 4'd0}},
    '{-1, '{OP_READ, 16'sd0, 1'b0, 4'd0, 10'd0}, 1'b1, '{16'sd0, STAT_RANGE, 4'd0}},
    '{2, '{OP_LOAD, 16'sh7fff, 1'b0, 4'd0, 10'd0}, 1'b1, '{16'sd0, STAT_OK, 4'd0}},
    '{-1, '{OP_LOAD, 16'sh7fff, 1'b0, 4'd0, 10'd0}, 1'b1, '{16'sd0, STAT_OK, 4'd0}},
    '{-1, '{OP_LOAD, 16'sh8000, 1'b0, 4'd0, 10'd0}, 1'b1, '{16'sd0, STAT_OK, 4'd0}},
    '{-1, '{OP_LOAD, 16'sh8000, 1'b1, 4'd0, 10'd0}, 1'b1, '{16'sd0, STAT_OK, 4'd2}},
    '{-1, '{OP_READ, 16'sd0, 1'b0, 4'd0, 10'd3}, 1'b0, '{16'sd0, STAT_OK, 4'd0}},
    '{-1, '{OP_READ, 16'sd0, 1'b0, 4'd1, 10'd0}, 1'b0, '{16'sd0, STAT_OK, 4'd0}},
    '{-1, '{OP_READ, 16'sd0, 1'b0, 4'd2, 10'd3}, 1'b0, '{16'sd0, STAT_OK, 4'd0}}
  };

  // Runs the levels of the transform over the closed block; 0 when levels is too large.
  function automatic bit modwt_compute(input int n);
    int top, nlev, s, b;
    logic signed [SW:0] sum, dif;
    top = 0;
    while (top < MAX_LEVELS_DEF && (2 << top) <= n) top++;
    pv_ok = 1'b0;
    if (pv_levels > top) begin
      pv_eff = '0;
      return 1'b0;
    end
    nlev = (pv_levels == 0) ? top : int'(pv_levels);
    for (int t = 0; t < n; t++) pv_work[t] = pv_buf[t];
    for (int j = 0; j < nlev; j++) begin
      s = (1 << j) % n;
      for (int t = 0; t < n; t++) begin
        b = (t + n - s) % n;
        dif = pv_work[t] - pv_work[b];
        sum = pv_work[t] + pv_work[b];
        pv_coef[j][t] = dif[SW:1];
        pv_coef[j+1][t] = sum[SW:1];
      end
      for (int t = 0; t < n; t++) pv_work[t] = pv_coef[j+1][t];
    end
    if (nlev == 0)
      for (int t = 0; t < n; t++) pv_coef[0][t] = pv_work[t];
    pv_len = n;
    pv_eff = LEVELS_W'(nlev);
    pv_ok = 1'b1;
    return 1'b1;
  endfunction

  function automatic coef_res_t modwt_step(input item_t it);
    coef_res_t r;
    r = '{val: '0, st: STAT_OK, lv: '0};
    if (it.op == OP_LOAD) begin
      if (pv_count < MAX_LEN_DEF) begin
        pv_buf[pv_count] = it.smp;
        pv_count++;
      end else begin
        r.st = STAT_DROP;
      end
      if (it.last) begin
        if (pv_count > 0 && !modwt_compute(pv_count)) r.st = STAT_LEVELS;
        pv_count = 0;
      end
    end else if (pv_ok && it.rw <= pv_eff && int'(it.pos) < pv_len) begin
      r.val = pv_coef[it.rw][it.pos];
    end else begin
      r.st = STAT_RANGE;
    end
    r.lv = pv_eff;
    return r;
  endfunction

  function automatic item_t mk_load(input logic signed [SW-1:0] smp, input logic last);
    return '{op: OP_LOAD, smp: smp, last: last, rw: '0, pos: '0};
  endfunction

  function automatic item_t mk_read(input logic [ROW_W-1:0] rw, input logic [POS_W-1:0] pos);
    return '{op: OP_READ, smp: SW'($urandom), last: 1'($urandom), rw: rw, pos: pos};
  endfunction

  function automatic logic signed [SW-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: begin
        return 16'sh7fff;
      end
      1: begin
        return 16'sh8000;
      end
      2: begin
        return '0;
      end
      3: begin
        return '1;
      end
      default: begin
        return SW'($urandom);
      end
    endcase
  endfunction

  // mostly reads inside the stored matrix, some anywhere
  function automatic item_t read_item();
    if (pv_ok && $urandom_range(0, 9) != 0)
      return mk_read(ROW_W'($urandom_range(0, pv_eff)), POS_W'($urandom_range(0, pv_len - 1)));
    return mk_read(ROW_W'($urandom), POS_W'($urandom));
  endfunction

  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(0, 24);
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
  endfunction

  // entered and left just after a falling edge
  task automatic offer(input item_t it, input bit typed = 1'b0, input coef_res_t want = '0);
    int gap;
    coef_res_t got;
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= it.op;
    sample <= it.smp;
    last_sample <= it.last;
    row <= it.rw;
    position <= it.pos;
    do @(posedge clk); while (in_stall);
    got = modwt_step(it);
    exp_q.push_back(typed ? want : got);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_xfer(input bit wr, input logic [DATA_W-1:0] wd,
                          output logic [DATA_W-1:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= LEVELS_ADDR;
    pwdata <= wd;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_levels(input int lv);
    logic [DATA_W-1:0] rd;
    apb_xfer(1'b1, DATA_W'(lv), rd);
    pv_levels = LEVELS_W'(lv);
    @(negedge clk);
    apb_xfer(1'b0, '0, rd);
    if (rd[LEVELS_W-1:0] !== pv_levels) begin
      $error("levels readback: expected %0d, got %0d", pv_levels, rd[LEVELS_W-1:0]);
      errs++;
    end
  endtask

  always @(posedge clk) begin : out_check
    coef_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (exp_q.size() == 0) begin
        $error("unexpected transfer: value %0d status %0d", value, status);
        errs++;
      end else begin
        want = exp_q.pop_front();
        if (value !== want.val) begin
          $error("value: expected %0d, got %0d", want.val, value);
          errs++;
        end
        if (status !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, status);
          errs++;
        end
        if (levels_used !== want.lv) begin
          $error("levels_used: expected %0d, got %0d", want.lv, levels_used);
          errs++;
        end
      end
    end
  end

  // receiver stall pattern, plus one long hold-off on request
  initial begin : rx_pattern
    int mode, span, hold;
    out_stall = 1'b0;
    mode = 0;
    span = 0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(8, 80);
        end
        span--;
        case (mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 3) == 0);
          end
          2: begin
            out_stall <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            out_stall <= ~out_stall;
          end
        endcase
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int r, n, lv, phase, start;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    operation = OP_LOAD;
    sample = '0;
    last_sample = 1'b0;
    row = '0;
    position = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].cfg >= 0) begin
        wait_idle();
        set_levels(dir_tab[i].cfg);
      end
      offer(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].res);
    end

    // full blocks: drops at capacity, first with levels too large, then all ten levels
    for (int k = 0; k < 2; k++) begin
      wait_idle();
      set_levels(k == 0 ? 15 : MAX_LEVELS_DEF);
      for (int i = 0; i < MAX_LEN_DEF; i++) offer(mk_load(rand_sample(), 1'b0));
      offer(mk_load(rand_sample(), 1'b0));
      offer(mk_load(rand_sample(), 1'b1));
    end
    offer(mk_read(ROW_W'(MAX_LEVELS_DEF), POS_W'(MAX_LEN_DEF - 1)));
    repeat (24) offer(read_item());

    phase = 0;
    start = n_sent;
    while (n_sent - start < 1000) begin
      wait_idle();
      r = $urandom_range(0, 9);
      if (r < 4) lv = 0;
      else if (r < 8) lv = $urandom_range(1, 4);
      else if (r == 8) lv = MAX_LEVELS_DEF;
      else lv = $urandom_range(5, 15);
      set_levels(lv);
      if (phase == 2) hold_req = 1'b1;
      repeat (2) begin
        r = $urandom_range(0, 19);
        if (r == 0) n = 1;
        else if (r == 1) n = 2;
        else if (r == 2) n = $urandom_range(64, 160);
        else n = $urandom_range(3, 40);
        for (int i = 0; i < n; i++) begin
          while ($urandom_range(0, 4) == 0) offer(read_item());
          offer(mk_load(rand_sample(), i == n - 1));
        end
        repeat ($urandom_range(2, 24)) offer(read_item());
      end
      phase++;
    end

    in_valid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errs == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
